>>> rtl/modulated_delay_allpass_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the modulated delay allpass block
// Shorthands for clocked concurrent assertions that are disabled during reset.
// ----------------------------------------------------------------------------
`ifndef MODULATED_DELAY_ALLPASS_MACROS_SVH
`define MODULATED_DELAY_ALLPASS_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define MDA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define MDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/mda_pkg.sv
// ----------------------------------------------------------------------------
// mda_pkg
// Widths, register indexes, reset values, shared types and a saturation helper for the
// modulated delay allpass block.
// ----------------------------------------------------------------------------
`default_nettype none

package mda_pkg;

  // Field widths
  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned COEF_W   = 16;
  localparam int unsigned K_W      = 17;   // coefficient after clamping, [-1.0, 1.0]
  localparam int unsigned DLEN_W   = 12;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // Shared multiplier operand and product widths
  localparam int unsigned OPA_W  = 26;
  localparam int unsigned OPB_W  = 17;
  localparam int unsigned PROD_W = 43;
  localparam int unsigned R15_W  = PROD_W - 15;
  localparam int unsigned R14_W  = PROD_W - 14;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAKEUP_GAIN  = 2'd2;

  // Reset values of the configuration registers
  localparam logic [CFG_W-1:0]  FEEDBACK_RST = 16'd0;
  localparam logic [DLEN_W-1:0] DLEN_RST     = 12'd1;
  localparam logic [CFG_W-1:0]  GAIN_RST     = 16'd16384;

  // Request to the shared multiplier
  typedef struct packed {
    logic                    en;
    logic signed [OPA_W-1:0] a;
    logic signed [OPB_W-1:0] b;
  } mac_req_t;

  // Rounded views of the registered product
  typedef struct packed {
    logic signed [R15_W-1:0] rnd15;
    logic signed [R14_W-1:0] rnd14;
  } mac_rsp_t;

  // Saturate a wide signed value to the 24-bit sample range.
  function automatic logic signed [SAMPLE_W-1:0] sat_sample(
    input logic signed [R14_W-1:0] v
  );
    logic signed [R14_W-1:0] hi;
    logic signed [R14_W-1:0] lo;
    hi = R14_W'(signed'(24'sh7fffff));
    lo = R14_W'(signed'(24'sh800000));
    if (v > hi) begin
      return 24'sh7fffff;
    end else if (v < lo) begin
      return 24'sh800000;
    end else begin
      return v[SAMPLE_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

>>> rtl/mda_mac.sv
// ----------------------------------------------------------------------------
// mda_mac
// Shared signed multiplier with a registered product and rounded outputs.
// ----------------------------------------------------------------------------
`default_nettype none

module mda_mac (
  input  wire logic              clk_i,
  input  wire mda_pkg::mac_req_t req_i,
  output mda_pkg::mac_rsp_t      rsp_o
);

  logic signed [mda_pkg::PROD_W-1:0] prod_q;
  logic signed [mda_pkg::PROD_W-1:0] prod_d;
  logic signed [mda_pkg::PROD_W-1:0] sum15;
  logic signed [mda_pkg::PROD_W-1:0] sum14;

  // One signed multiply per enabled cycle.
  always_comb begin
    prod_d = mda_pkg::PROD_W'(req_i.a) * mda_pkg::PROD_W'(req_i.b);
  end

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= prod_d;
    end
  end

  // Round to nearest, ties upward: add half, then keep the upper bits.
  assign sum15 = prod_q + mda_pkg::PROD_W'(signed'(16'sd16384));
  assign sum14 = prod_q + mda_pkg::PROD_W'(signed'(16'sd8192));

  assign rsp_o.rnd15 = sum15[mda_pkg::PROD_W-1:15];
  assign rsp_o.rnd14 = sum14[mda_pkg::PROD_W-1:14];

endmodule

`default_nettype wire

>>> rtl/mda_delay_ram.sv
// ----------------------------------------------------------------------------
// mda_delay_ram
// Circular delay memory: one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mda_delay_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  wire logic                                clk_i,
  input  wire logic                                we_i,
  input  wire logic [AW-1:0]                       waddr_i,
  input  wire logic signed [mda_pkg::SAMPLE_W-1:0] wdata_i,
  input  wire logic                                re_i,
  input  wire logic [AW-1:0]                       raddr_i,
  output logic signed [mda_pkg::SAMPLE_W-1:0]      rdata_o
);

  logic signed [mda_pkg::SAMPLE_W-1:0] mem [DEPTH];
  logic signed [mda_pkg::SAMPLE_W-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/modulated_delay_allpass.sv
// ----------------------------------------------------------------------------
// modulated_delay_allpass
// Schroeder allpass filter on a circular delay memory with a modulated
// coefficient, output make-up gain and 24-bit saturation.
// ----------------------------------------------------------------------------
// After reset the block writes zero to every location of the delay memory
// and accepts no sample meanwhile. Configuration writes are taken at any
// time, but they should only be made while no sample is in progress. After
// a sample is accepted the input stays not ready while the sequencer steps
// through REDUCE, which takes DELAY_DEPTH off its copy of the delay length
// until it is below DELAY_DEPTH, then MULD, W, MULW, PRE, MULG and OUT, so
// no new sample is taken before the last one is through. This sequence is
// set by the single shared multiplier, which forms k*d, k*w and the gained
// output one after the other, and by the registered read of the delay
// memory. The result waits in an output register, so a new sample is
// accepted while the previous result is still waiting to be taken. If that
// previous result has still not been taken when the new one is ready, the
// last step holds, and the input stays not ready, until it has gone.
// ----------------------------------------------------------------------------
`default_nettype none

module modulated_delay_allpass #(
  parameter int unsigned DELAY_DEPTH = 4096
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Sample input: [23:0] sample_in, [39:24] coef_mod
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  wire logic [39:0]                     s_axis_tdata_i,
  // Sample output: [23:0] sample_out
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  output logic [23:0]                          m_axis_tdata_o,
  // Configuration write port
  input  wire logic                            cfg_we_i,
  input  wire logic [mda_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [mda_pkg::CFG_W-1:0]       cfg_data_i
);

`include "modulated_delay_allpass_macros.svh"

  localparam int unsigned AW = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
  localparam int unsigned SW = AW + 2;

  // Sequencer states
  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_REDUCE = 4'd2;
  localparam logic [3:0] ST_MULD   = 4'd3;
  localparam logic [3:0] ST_W      = 4'd4;
  localparam logic [3:0] ST_MULW   = 4'd5;
  localparam logic [3:0] ST_PRE    = 4'd6;
  localparam logic [3:0] ST_MULG   = 4'd7;
  localparam logic [3:0] ST_OUT    = 4'd8;

  logic [3:0] state_q, state_d;

  // Configuration registers
  logic [mda_pkg::CFG_W-1:0]  feedback_q;
  logic [mda_pkg::DLEN_W-1:0] delay_len_q;
  logic [mda_pkg::CFG_W-1:0]  gain_q;

  // Control state
  logic [AW-1:0] wp_q, wp_d;
  logic [AW-1:0] clr_cnt_q, clr_cnt_d;
  logic          out_valid_q, out_valid_d;

  // Working registers of the current sample
  logic [mda_pkg::DLEN_W-1:0]          back_q, back_d;
  logic signed [mda_pkg::SAMPLE_W-1:0] x_q, x_d;
  logic signed [mda_pkg::K_W-1:0]      k_q, k_d;
  logic signed [mda_pkg::SAMPLE_W-1:0] d_q, d_d;
  logic signed [mda_pkg::SAMPLE_W-1:0] w_q, w_d;
  logic signed [mda_pkg::OPA_W-1:0]    pre_q, pre_d;
  logic [mda_pkg::SAMPLE_W-1:0]        out_data_q, out_data_d;

  // Unit connections
  logic                                ram_we;
  logic [AW-1:0]                       ram_waddr;
  logic signed [mda_pkg::SAMPLE_W-1:0] ram_wdata;
  logic                                ram_re;
  logic [AW-1:0]                       ram_raddr;
  logic signed [mda_pkg::SAMPLE_W-1:0] ram_rdata;
  mda_pkg::mac_req_t                   mac_req;
  mda_pkg::mac_rsp_t                   mac_rsp;

  // Combinational helpers
  logic                                in_fire;
  logic signed [mda_pkg::COEF_W-1:0]   coef_in;
  logic signed [mda_pkg::COEF_W+1:0]   k_diff;
  logic [SW-1:0]                       rp_sum;
  logic [SW-1:0]                       rp_wrap;
  logic signed [mda_pkg::R14_W-1:0]    w_sum;
  logic signed [mda_pkg::R14_W-1:0]    pre_sum;

  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;
  assign coef_in = s_axis_tdata_i[39:24];

  // Configuration writes; an index beyond the list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      feedback_q  <= mda_pkg::FEEDBACK_RST;
      delay_len_q <= mda_pkg::DLEN_RST;
      gain_q      <= mda_pkg::GAIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mda_pkg::CFG_FEEDBACK:     feedback_q  <= cfg_data_i;
        mda_pkg::CFG_DELAY_LENGTH: delay_len_q <= cfg_data_i[mda_pkg::DLEN_W-1:0];
        mda_pkg::CFG_MAKEUP_GAIN:  gain_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective coefficient m - feedback, clamped to [-1.0, 1.0].
  always_comb begin
    k_diff = (mda_pkg::COEF_W+2)'(coef_in)
           - $signed({2'b00, feedback_q});
    if (k_diff < -18'sd32768) begin
      k_d = -17'sd32768;
    end else if (k_diff > 18'sd32768) begin
      k_d = 17'sd32768;
    end else begin
      k_d = k_diff[mda_pkg::K_W-1:0];
    end
  end

  // Read position: write pointer minus the reduced delay, modulo the depth.
  always_comb begin
    rp_sum  = SW'(wp_q) + SW'(DELAY_DEPTH) - SW'(back_q);
    rp_wrap = (rp_sum >= SW'(DELAY_DEPTH)) ? (rp_sum - SW'(DELAY_DEPTH)) : rp_sum;
  end

  // Feedback sum and feedforward difference at full width.
  assign w_sum   = mda_pkg::R14_W'(x_q) + mda_pkg::R14_W'(mac_rsp.rnd15);
  assign pre_sum = mda_pkg::R14_W'(d_q) - mda_pkg::R14_W'(mac_rsp.rnd15);

  // Sequencer: drives the shared multiplier and the delay memory.
  always_comb begin
    state_d     = state_q;
    wp_d        = wp_q;
    clr_cnt_d   = clr_cnt_q;
    out_valid_d = out_valid_q;
    back_d      = back_q;
    x_d         = x_q;
    d_d         = d_q;
    w_d         = w_q;
    pre_d       = pre_q;
    out_data_d  = out_data_q;

    ram_we    = 1'b0;
    ram_waddr = wp_q;
    ram_wdata = w_q;
    ram_re    = 1'b0;
    ram_raddr = rp_wrap[AW-1:0];

    mac_req.en = 1'b0;
    mac_req.a  = mda_pkg::OPA_W'(d_q);
    mac_req.b  = k_q;

    s_axis_tready_o = 1'b0;

    // The output register empties when its transaction completes.
    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = '0;
        clr_cnt_d = clr_cnt_q + AW'(1);
        if (clr_cnt_q == AW'(DELAY_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          x_d     = s_axis_tdata_i[23:0];
          back_d  = delay_len_q;
          state_d = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (32'(back_q) >= 32'(DELAY_DEPTH)) begin
          back_d = back_q - mda_pkg::DLEN_W'(DELAY_DEPTH);
        end else begin
          ram_re  = 1'b1;
          state_d = ST_MULD;
        end
      end
      ST_MULD: begin
        d_d        = ram_rdata;
        mac_req.en = 1'b1;
        mac_req.a  = mda_pkg::OPA_W'(ram_rdata);
        state_d    = ST_W;
      end
      ST_W: begin
        w_d       = mda_pkg::sat_sample(w_sum);
        ram_we    = 1'b1;
        ram_wdata = w_d;
        wp_d      = (wp_q == AW'(DELAY_DEPTH - 1)) ? '0 : wp_q + AW'(1);
        state_d   = ST_MULW;
      end
      ST_MULW: begin
        mac_req.en = 1'b1;
        mac_req.a  = mda_pkg::OPA_W'(w_q);
        state_d    = ST_PRE;
      end
      ST_PRE: begin
        pre_d   = pre_sum[mda_pkg::OPA_W-1:0];
        state_d = ST_MULG;
      end
      ST_MULG: begin
        mac_req.en = 1'b1;
        mac_req.a  = pre_q;
        mac_req.b  = $signed({1'b0, gain_q});
        state_d    = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_data_d  = mda_pkg::sat_sample(mac_rsp.rnd14);
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      wp_q        <= '0;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    back_q     <= back_d;
    x_q        <= x_d;
    d_q        <= d_d;
    w_q        <= w_d;
    pre_q      <= pre_d;
    out_data_q <= out_data_d;
    if (in_fire) begin
      k_q <= k_d;
    end
  end

  mda_delay_ram #(
    .DEPTH (DELAY_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  mda_mac u_mac (
    .clk_i (clk_i),
    .req_i (mac_req),
    .rsp_o (mac_rsp)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // Assertions
  `MDA_ASSERT_IMPL(a_no_accept_in_clear, state_q == ST_CLEAR, !s_axis_tready_o,
                   "sample accepted during the memory clearing pass")
  `MDA_ASSERT_IMPL(a_read_in_range, ram_re, 32'(ram_raddr) < 32'(DELAY_DEPTH),
                   "delay memory read beyond its depth")
  `MDA_ASSERT_NEXT(a_out_from_seq, !out_valid_q && state_q != ST_OUT, !out_valid_q,
                   "result appeared without passing the output step")
  `MDA_ASSERT_NEXT(a_ptr_step, state_q == ST_W,
                   wp_q == (($past(wp_q) == AW'(DELAY_DEPTH - 1)) ? '0 : $past(wp_q) + AW'(1)),
                   "write pointer did not advance by one after a store")

endmodule

`default_nettype wire

>>> verif/tb_modulated_delay_allpass.sv
// ----------------------------------------------------------------------------
// tb_modulated_delay_allpass
// Self-checking testbench for the modulated delay allpass filter. A behavioural
// allpass filter with its own delay memory predicts every output sample when
// the input transaction is taken. Each output transaction is checked against
// the oldest prediction. Directed field and register extremes are followed by
// random phases under several idling patterns and one long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_modulated_delay_allpass;

  localparam int unsigned DEPTH        = 4096;
  localparam int unsigned LIMIT_CYCLES = 250000;
  // Index past the register list; writes to it must be ignored.
  localparam logic [mda_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic signed [mda_pkg::SAMPLE_W-1:0] SMP_MAX = 24'sh7fffff;
  localparam logic signed [mda_pkg::SAMPLE_W-1:0] SMP_MIN = 24'sh800000;
  localparam logic signed [mda_pkg::COEF_W-1:0]   COEF_MAX = 16'sh7fff;
  localparam logic signed [mda_pkg::COEF_W-1:0]   COEF_MIN = 16'sh8000;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                          s_axis_tvalid_i;
  logic                          s_axis_tready_o;
  logic [39:0]                   s_axis_tdata_i;   // [23:0] sample_in, [39:24] coef_mod
  logic                          m_axis_tvalid_o;
  logic                          m_axis_tready_i;
  logic [23:0]                   m_axis_tdata_o;   // [23:0] sample_out
  logic                          cfg_we_i;
  logic [mda_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [mda_pkg::CFG_W-1:0]     cfg_data_i;

  // Filter model state
  logic signed [mda_pkg::SAMPLE_W-1:0] echo_mem [DEPTH];
  logic [mda_pkg::DLEN_W-1:0]          echo_wptr;
  logic [mda_pkg::CFG_W-1:0]           feedback_q;
  logic [mda_pkg::DLEN_W-1:0]          delay_len_q;
  logic [mda_pkg::CFG_W-1:0]           gain_q;

  logic [mda_pkg::SAMPLE_W-1:0] expected_samples [$];
  int                           err_cnt;
  int unsigned                  cycle_cnt;
  int                           tx_idle_pct;
  int                           rx_idle_pct;
  int                           rx_hold_cnt;

  modulated_delay_allpass u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i)
  );

  // 8 ns clock.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Round to nearest, ties towards plus infinity, then shift.
  function automatic longint round_shr(input longint v, input int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint sat24(input longint v);
    if (v > longint'(SMP_MAX)) return longint'(SMP_MAX);
    if (v < longint'(SMP_MIN)) return longint'(SMP_MIN);
    return v;
  endfunction

  // One allpass step: read the delayed value, store the new one, form the output.
  function automatic logic [mda_pkg::SAMPLE_W-1:0] allpass_step(
    input logic signed [mda_pkg::SAMPLE_W-1:0] x,
    input logic signed [mda_pkg::COEF_W-1:0]   m
  );
    longint                     k;
    longint                     d;
    longint                     w;
    longint                     pre;
    logic [mda_pkg::DLEN_W-1:0] rd_idx;
    k = longint'(m) - longint'(feedback_q);
    if (k < -32768) k = -32768;
    if (k > 32768) k = 32768;
    rd_idx = echo_wptr - delay_len_q;
    d = longint'(echo_mem[rd_idx]);
    w = sat24(longint'(x) + round_shr(k * d, 15));
    echo_mem[echo_wptr] = w[mda_pkg::SAMPLE_W-1:0];
    echo_wptr = echo_wptr + 1'b1;
    pre = d - round_shr(k * w, 15);
    return mda_pkg::SAMPLE_W'(sat24(round_shr(pre * longint'(gain_q), 14)));
  endfunction

  // Model update and output check, all sampled at the rising edge.
  always @(posedge clk_i) begin
    logic [mda_pkg::SAMPLE_W-1:0] want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          mda_pkg::CFG_FEEDBACK:     feedback_q  = cfg_data_i;
          mda_pkg::CFG_DELAY_LENGTH: delay_len_q = cfg_data_i[mda_pkg::DLEN_W-1:0];
          mda_pkg::CFG_MAKEUP_GAIN:  gain_q      = cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        expected_samples.push_back(allpass_step(s_axis_tdata_i[23:0], s_axis_tdata_i[39:24]));
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (expected_samples.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected output transaction, expected none, actual %0d",
                   $time, $signed(m_axis_tdata_o));
        end else begin
          want = expected_samples.pop_front();
          if (m_axis_tdata_o !== want) begin
            err_cnt++;
            $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                     $time, $signed(want), $signed(m_axis_tdata_o));
          end
        end
      end
    end
  end

  // Output ready: a counted hold-off when requested, otherwise random idling.
  always @(posedge clk_i) begin
    if (rx_hold_cnt > 0) begin
      rx_hold_cnt--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Offer one sample and wait until the transaction is taken; valid stays high.
  task automatic send_sample(input logic [23:0] smp, input logic [15:0] cm);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {cm, smp};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  // Stop offering and wait until every predicted sample has come out.
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_samples.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [mda_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mda_pkg::CFG_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_random_sample();
    logic [23:0] smp;
    logic [15:0] cm;
    case ($urandom_range(15))
      0:       smp = SMP_MAX;
      1:       smp = SMP_MIN;
      2:       smp = 24'($urandom_range(0, 255)) - 24'd128;
      default: smp = 24'($urandom);
    endcase
    case ($urandom_range(11)) inside
      [0:2]:   cm = '0;
      3:       cm = COEF_MAX;
      4:       cm = COEF_MIN;
      default: cm = 16'($urandom);
    endcase
    send_sample(smp, cm);
  endtask

  // Pick a fresh setting for every register; the block must be idle.
  task automatic randomise_regs();
    logic [mda_pkg::CFG_W-1:0] val;
    case ($urandom_range(9))
      0:       val = 16'($urandom_range(32769, 65535));
      1:       val = 16'd32768;
      2:       val = '0;
      default: val = 16'($urandom_range(0, 32768));
    endcase
    write_reg(mda_pkg::CFG_FEEDBACK, val);
    // Upper bits of the delay length write are don't-care.
    case ($urandom_range(7))
      0:       val = {4'($urandom), 12'($urandom_range(0, 4095))};
      1:       val = {4'($urandom), 12'd0};
      default: val = {4'($urandom), 12'($urandom_range(1, 24))};
    endcase
    write_reg(mda_pkg::CFG_DELAY_LENGTH, val);
    if ($urandom_range(3) == 0) val = 16'($urandom);
    else val = 16'($urandom_range(8192, 24576));
    write_reg(mda_pkg::CFG_MAKEUP_GAIN, val);
    if ($urandom_range(4) == 0) write_reg(CFG_UNUSED, 16'($urandom));
  endtask

  // Field extremes with the reset register values.
  task automatic test_field_extremes();
    send_sample(SMP_MAX, '0);
    send_sample(SMP_MIN, '0);
    send_sample('0, '0);
    send_sample(24'hffffff, COEF_MAX);
    send_sample(SMP_MAX, COEF_MIN);
    send_sample(SMP_MIN, COEF_MAX);
    send_sample(24'd12345, 16'hffff);
    drain();
  endtask

  // Register extremes: unity and beyond-unity feedback, gain limits,
  // zero and maximum delay length, and the unused register index.
  task automatic test_register_extremes();
    write_reg(mda_pkg::CFG_FEEDBACK, 16'd32768);
    send_sample(SMP_MAX, '0);
    send_sample(SMP_MIN, COEF_MIN);
    drain();
    write_reg(mda_pkg::CFG_FEEDBACK, 16'hffff);
    send_sample(24'd4000000, COEF_MAX);
    send_sample(SMP_MIN, '0);
    drain();
    write_reg(mda_pkg::CFG_MAKEUP_GAIN, 16'hffff);
    send_sample(SMP_MAX, '0);
    send_sample(SMP_MIN, COEF_MAX);
    drain();
    write_reg(mda_pkg::CFG_MAKEUP_GAIN, '0);
    send_sample(SMP_MAX, COEF_MIN);
    drain();
    write_reg(mda_pkg::CFG_DELAY_LENGTH, 16'hf000);
    write_reg(mda_pkg::CFG_MAKEUP_GAIN, 16'd16384);
    send_sample(24'd777, COEF_MAX);
    send_sample(SMP_MIN, '0);
    drain();
    write_reg(mda_pkg::CFG_DELAY_LENGTH, 16'h0fff);
    send_sample(SMP_MAX, COEF_MIN);
    send_sample(24'h123456, 16'h4000);
    drain();
    write_reg(CFG_UNUSED, 16'hffff);
    send_sample(SMP_MIN, COEF_MAX);
    drain();
    write_reg(mda_pkg::CFG_FEEDBACK, 16'd16384);
    write_reg(mda_pkg::CFG_DELAY_LENGTH, 16'd1);
  endtask

  // Random samples in chunks, with new register settings between chunks.
  task automatic test_random_phase(input int n_chunks, input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int c = 0; c < n_chunks; c++) begin
      randomise_regs();
      for (int i = 0; i < 45; i++) send_random_sample();
      drain();
    end
  endtask

  // Long output hold-off while samples keep arriving, so the input stalls.
  task automatic test_output_holdoff();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_reg(mda_pkg::CFG_DELAY_LENGTH, 16'd3);
    rx_hold_cnt = 400;
    for (int i = 0; i < 40; i++) send_random_sample();
    drain();
  endtask

  initial begin
    err_cnt         = 0;
    cycle_cnt       = 0;
    tx_idle_pct     = 0;
    rx_idle_pct     = 0;
    rx_hold_cnt     = 0;
    echo_wptr       = '0;
    feedback_q      = mda_pkg::FEEDBACK_RST;
    delay_len_q     = mda_pkg::DLEN_RST;
    gain_q          = mda_pkg::GAIN_RST;
    foreach (echo_mem[i]) echo_mem[i] = '0;
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= '0;
    cfg_data_i      <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_field_extremes();
    test_register_extremes();
    test_random_phase(6, 7, 45);
    test_random_phase(6, 45, 7);
    test_random_phase(6, 0, 0);
    test_output_holdoff();

    repeat (20) @(posedge clk_i);
    if (err_cnt == 0 && expected_samples.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/mda_pkg.sv
rtl/mda_mac.sv
rtl/mda_delay_ram.sv
rtl/modulated_delay_allpass.sv
verif/tb_modulated_delay_allpass.sv
